// ----- sv/tsct_pkg.sv -----
// ----------------------------------------------------------------------------
// Taylor sine, cosine and tangent: shared package
// Holds the number formats, the constants, the sequencer states and the
// request structure of the shared multiply/divide unit.
// ----------------------------------------------------------------------------
package tsct_pkg;

    localparam int FRAC_BITS = 28;
    localparam int EPS_W     = 28;
    localparam int DATA_W    = 48;              // x, x^2, terms and sums
    localparam int MUL_W     = 40;              // multiplier operand magnitude
    localparam int WIDE_W    = 80;              // product / numerator register
    localparam int LEN_W     = 7;
    localparam int VAL_W     = 40;

    localparam logic [63:0] TWO_PI_Q61 = 64'hC90FDAA22168C235;
    localparam logic [63:0] TWO_PI_Q  =
        (TWO_PI_Q61 + (64'd1 << (60 - FRAC_BITS))) >> (61 - FRAC_BITS);

    localparam logic [1:0] REQ_SIN  = 2'd0;
    localparam logic [1:0] REQ_COS  = 2'd1;
    localparam logic [1:0] REQ_TAN  = 2'd2;
    localparam logic [1:0] REQ_NONE = 2'd3;

    localparam logic [LEN_W-1:0] MUL_LEN  = LEN_W'(MUL_W);
    localparam logic [LEN_W-1:0] TERM_LEN = LEN_W'(DATA_W);
    localparam logic [LEN_W-1:0] TAN_LEN  = LEN_W'(DATA_W + FRAC_BITS + 1);

    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    typedef enum logic {
        ALU_MUL,
        ALU_DIV
    } alu_op_t;

    typedef struct packed {
        logic             start;
        alu_op_t          op;
        logic [LEN_W-1:0] len;
    } alu_req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_X2W,
        ST_INIT,
        ST_CHECK,
        ST_MULW,
        ST_DIVGO,
        ST_DIVW,
        ST_SDONE,
        ST_TDIVW,
        ST_OUT
    } state_t;

    function automatic logic [DATA_W-1:0] mag(input logic signed [DATA_W-1:0] v);
        logic [DATA_W-1:0] r;
        r = v[DATA_W-1] ? DATA_W'(-v) : DATA_W'(v);
        return r;
    endfunction

endpackage

// ----- sv/tsct_alu.sv -----
// ----------------------------------------------------------------------------
// Taylor sine, cosine and tangent: shared arithmetic unit
// One adder serves a shift-and-add multiplier and a restoring divider, one
// bit per cycle. done pulses for one cycle when the result is ready.
// ----------------------------------------------------------------------------
module tsct_alu (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tsct_pkg::alu_req_t            req,
    input  logic [tsct_pkg::WIDE_W-1:0]   opa,
    input  logic [tsct_pkg::DATA_W-1:0]   opb,
    output logic [tsct_pkg::WIDE_W-1:0]   result,
    output logic                          done
);

    localparam int AW = tsct_pkg::DATA_W + 2;
    localparam int MW = tsct_pkg::MUL_W;
    localparam int WW = tsct_pkg::WIDE_W;
    localparam int DW = tsct_pkg::DATA_W;

    tsct_pkg::alu_op_t            op_reg, op_next;
    logic [WW-1:0]                acc_reg, acc_next;
    logic [DW-1:0]                rem_reg, rem_next;
    logic [DW-1:0]                mc_reg, mc_next;
    logic [tsct_pkg::LEN_W-1:0]   cnt_reg, cnt_next;
    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;

    logic [AW-1:0]                add_x, add_y, add_s;
    logic                         add_sub;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= tsct_pkg::ALU_MUL;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            op_reg   <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        mc_reg  <= mc_next;
    end

    // The one adder: accumulate for multiply, trial subtract for divide.
    always_comb
    begin
        if (op_reg == tsct_pkg::ALU_MUL)
        begin
            add_x   = AW'(acc_reg[WW-1:MW]);
            add_y   = acc_reg[0] ? AW'(mc_reg[MW-1:0]) : '0;
            add_sub = 1'b0;
        end
        else
        begin
            add_x   = {1'b0, rem_reg, acc_reg[WW-1]};
            add_y   = AW'(mc_reg);
            add_sub = 1'b1;
        end
        add_s = add_x + (add_sub ? ~add_y : add_y) + AW'(add_sub);
    end

    always_comb
    begin
        op_next   = op_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        mc_next   = mc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            op_next   = req.op;
            cnt_next  = req.len;
            busy_next = 1'b1;
            mc_next   = opb;
            rem_next  = '0;
            acc_next  = (req.op == tsct_pkg::ALU_MUL) ? WW'(opa[MW-1:0]) : opa;
        end
        else if (busy_reg)
        begin
            if (op_reg == tsct_pkg::ALU_MUL)
            begin
                acc_next = {add_s[MW:0], acc_reg[MW-1:1]};
            end
            else if (!add_s[AW-1])
            begin
                rem_next = add_s[DW-1:0];
                acc_next = {acc_reg[WW-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[DW-2:0], acc_reg[WW-1]};
                acc_next = {acc_reg[WW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == tsct_pkg::LEN_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign result = acc_reg;
    assign done   = done_reg;

endmodule

// ----- sv/taylor_sine_cosine_tangent_unit.sv -----
// ----------------------------------------------------------------------------
// Taylor sine, cosine and tangent unit
// Reduces a Q4.28 angle to [0, 2pi), sums the Taylor series on a shared
// bit-serial multiply/divide unit and returns a saturated Q12.28 result.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  in       input      in_valid / in_stall    req_type, angle
//  out      output     out_valid / out_stall  value, saturated, cos_near_zero
//  cfg      input      cfg_valid / cfg_ready  cfg_data (epsilon)
//
// x^2 is computed first; each series term is then a multiply, a divide by the
// term's constant and bookkeeping, for at most MAX_TERMS-1 terms. Tangent
// runs both series and a final divide.
// One item at a time: in_stall is high from acceptance until the result
// transfer. Reset clears the control state and sets epsilon to 1.
// ----------------------------------------------------------------------------
module taylor_sine_cosine_tangent_unit #(
    parameter int MAX_TERMS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          req_type,
    input  logic signed [31:0]  angle,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [39:0]  value,
    output logic                saturated,
    output logic                cos_near_zero,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [27:0]         cfg_data
);

    localparam int DW = tsct_pkg::DATA_W;
    localparam int WW = tsct_pkg::WIDE_W;
    localparam int FB = tsct_pkg::FRAC_BITS;
    localparam int VW = tsct_pkg::VAL_W;
    localparam int NW = $clog2(MAX_TERMS + 1);
    localparam int KW = 2 * (NW + 1);

    tsct_pkg::state_t           state_reg, state_next;
    logic [1:0]                 sel_reg, sel_next;
    logic                       phase_reg, phase_next;
    logic [NW-1:0]              n_reg, n_next;
    logic [tsct_pkg::EPS_W-1:0] eps_reg;
    logic signed [DW-1:0]       x_reg, x_next;
    logic signed [DW-1:0]       x2_reg, x2_next;
    logic signed [DW-1:0]       term_reg, term_next;
    logic signed [DW-1:0]       sum_reg, sum_next;
    logic signed [DW-1:0]       s_reg, s_next;
    logic [DW-1:0]              prod_reg, prod_next;
    logic [KW-1:0]              d_reg, d_next;
    logic signed [VW-1:0]       value_reg, value_next;
    logic                       sat_reg, sat_next;
    logic                       near_reg, near_next;

    tsct_pkg::alu_req_t         alu_req;
    logic [WW-1:0]              alu_opa;
    logic [DW-1:0]              alu_opb;
    logic [WW-1:0]              alu_result;
    logic                       alu_done;

    logic signed [33:0]         a_ext, tp, r1, r2, rs, red;
    logic                       is_cos;
    logic [DW-1:0]              term_mag, sum_mag, eps_ext, quo;
    logic [WW-1:0]              rnd_prod;
    logic [NW:0]                n2;
    logic                       t_neg;
    logic [VW:0]                m_rnd;
    logic [VW-1:0]              m_val;

    tsct_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (alu_req),
        .opa    (alu_opa),
        .opb    (alu_opb),
        .result (alu_result),
        .done   (alu_done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tsct_pkg::ST_IDLE;
            eps_reg   <= tsct_pkg::EPS_W'(1);
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                eps_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sel_reg   <= sel_next;
        phase_reg <= phase_next;
        n_reg     <= n_next;
        x_reg     <= x_next;
        x2_reg    <= x2_next;
        term_reg  <= term_next;
        sum_reg   <= sum_next;
        s_reg     <= s_next;
        prod_reg  <= prod_next;
        d_reg     <= d_next;
        value_reg <= value_next;
        sat_reg   <= sat_next;
        near_reg  <= near_next;
    end

    // Floor modulo by 2pi: the input range needs at most two corrections.
    always_comb
    begin
        a_ext = 34'(angle);
        tp    = 34'(tsct_pkg::TWO_PI_Q);
        r1    = a_ext + tp;
        r2    = r1 + tp;
        rs    = a_ext - tp;
        if (a_ext < 0)
        begin
            red = (r1 < 0) ? r2 : r1;
        end
        else
        begin
            red = (a_ext >= tp) ? rs : a_ext;
        end
    end

    always_comb
    begin
        is_cos   = (sel_reg == tsct_pkg::REQ_COS) || phase_reg;
        term_mag = tsct_pkg::mag(term_reg);
        sum_mag  = tsct_pkg::mag(sum_reg);
        eps_ext  = DW'(eps_reg);
        rnd_prod = alu_result + (WW'(1) << (FB - 1));
        n2       = {n_reg, 1'b0};
        quo      = alu_result[DW-1:0];
        t_neg    = s_reg[DW-1] ^ sum_reg[DW-1];
        m_rnd    = ({1'b0, alu_result[VW-1:0]} + (VW+1)'(1)) >> 1;
        m_val    = m_rnd[VW-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        phase_next = phase_reg;
        n_next     = n_reg;
        x_next     = x_reg;
        x2_next    = x2_reg;
        term_next  = term_reg;
        sum_next   = sum_reg;
        s_next     = s_reg;
        prod_next  = prod_reg;
        d_next     = d_reg;
        value_next = value_reg;
        sat_next   = sat_reg;
        near_next  = near_reg;
        alu_req    = '{start: 1'b0, op: tsct_pkg::ALU_MUL, len: tsct_pkg::MUL_LEN};
        alu_opa    = '0;
        alu_opb    = '0;

        unique case (state_reg)
            tsct_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    sel_next   = req_type;
                    phase_next = 1'b0;
                    x_next     = DW'(red);
                    value_next = '0;
                    sat_next   = 1'b0;
                    near_next  = 1'b0;
                    if (req_type == tsct_pkg::REQ_SIN || req_type == tsct_pkg::REQ_COS
                        || req_type == tsct_pkg::REQ_TAN)
                    begin
                        // The reduced angle is never negative, so widening keeps it.
                        alu_req.start = 1'b1;
                        alu_opa       = WW'(red);
                        alu_opb       = DW'(red);
                        state_next    = tsct_pkg::ST_X2W;
                    end
                    else
                    begin
                        state_next = tsct_pkg::ST_OUT;
                    end
                end
            end
            tsct_pkg::ST_X2W:
            begin
                if (alu_done)
                begin
                    x2_next    = rnd_prod[FB +: DW];
                    state_next = tsct_pkg::ST_INIT;
                end
            end
            tsct_pkg::ST_INIT:
            begin
                term_next  = is_cos ? (DW'(1) << FB) : x_reg;
                sum_next   = is_cos ? (DW'(1) << FB) : x_reg;
                n_next     = NW'(1);
                state_next = tsct_pkg::ST_CHECK;
            end
            tsct_pkg::ST_CHECK:
            begin
                if (n_reg < NW'(MAX_TERMS) && term_mag >= eps_ext)
                begin
                    d_next        = is_cos ? KW'(n2) * KW'(n2 - 1'b1)
                                           : KW'(n2) * KW'(n2 + 1'b1);
                    alu_req.start = 1'b1;
                    alu_opa       = WW'(term_mag[tsct_pkg::MUL_W-1:0]);
                    alu_opb       = DW'(x2_reg[tsct_pkg::MUL_W-1:0]);
                    state_next    = tsct_pkg::ST_MULW;
                end
                else
                begin
                    state_next = tsct_pkg::ST_SDONE;
                end
            end
            tsct_pkg::ST_MULW:
            begin
                if (alu_done)
                begin
                    prod_next  = rnd_prod[FB +: DW];
                    state_next = tsct_pkg::ST_DIVGO;
                end
            end
            tsct_pkg::ST_DIVGO:
            begin
                // Adding half the divisor gives rounding half away from zero.
                alu_req.start = 1'b1;
                alu_req.op    = tsct_pkg::ALU_DIV;
                alu_req.len   = tsct_pkg::TERM_LEN;
                alu_opa       = {prod_reg + DW'(d_reg >> 1), (WW-DW)'(0)};
                alu_opb       = DW'(d_reg);
                state_next    = tsct_pkg::ST_DIVW;
            end
            tsct_pkg::ST_DIVW:
            begin
                if (alu_done)
                begin
                    term_next  = term_reg[DW-1] ? signed'(quo) : -signed'(quo);
                    sum_next   = sum_reg + (term_reg[DW-1] ? signed'(quo) : -signed'(quo));
                    n_next     = n_reg + 1'b1;
                    state_next = tsct_pkg::ST_CHECK;
                end
            end
            tsct_pkg::ST_SDONE:
            begin
                if (sel_reg == tsct_pkg::REQ_TAN && !phase_reg)
                begin
                    s_next     = sum_reg;
                    phase_next = 1'b1;
                    state_next = tsct_pkg::ST_INIT;
                end
                else if (sel_reg == tsct_pkg::REQ_TAN)
                begin
                    if (sum_mag < eps_ext || sum_mag == '0)
                    begin
                        near_next  = 1'b1;
                        value_next = '0;
                        state_next = tsct_pkg::ST_OUT;
                    end
                    else
                    begin
                        alu_req.start = 1'b1;
                        alu_req.op    = tsct_pkg::ALU_DIV;
                        alu_req.len   = tsct_pkg::TAN_LEN;
                        alu_opa       = {tsct_pkg::mag(s_reg), (WW-DW)'(0)};
                        alu_opb       = sum_mag;
                        state_next    = tsct_pkg::ST_TDIVW;
                    end
                end
                else
                begin
                    if (sum_reg[DW-1:VW-1] != '0 && sum_reg[DW-1:VW-1] != '1)
                    begin
                        sat_next   = 1'b1;
                        value_next = sum_reg[DW-1] ? tsct_pkg::VAL_MIN : tsct_pkg::VAL_MAX;
                    end
                    else
                    begin
                        value_next = sum_reg[VW-1:0];
                    end
                    state_next = tsct_pkg::ST_OUT;
                end
            end
            tsct_pkg::ST_TDIVW:
            begin
                if (alu_done)
                begin
                    // The quotient carries FRAC_BITS+1 fraction bits before rounding.
                    if (alu_result[WW-1:VW] != '0)
                    begin
                        sat_next   = 1'b1;
                        value_next = t_neg ? tsct_pkg::VAL_MIN : tsct_pkg::VAL_MAX;
                    end
                    else if (!t_neg && m_val[VW-1])
                    begin
                        sat_next   = 1'b1;
                        value_next = tsct_pkg::VAL_MAX;
                    end
                    else
                    begin
                        value_next = t_neg ? -signed'(m_val) : signed'(m_val);
                    end
                    state_next = tsct_pkg::ST_OUT;
                end
            end
            tsct_pkg::ST_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = tsct_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tsct_pkg::ST_IDLE;
            end
        endcase
    end

    assign in_stall      = (state_reg != tsct_pkg::ST_IDLE);
    assign out_valid     = (state_reg == tsct_pkg::ST_OUT);
    assign value         = value_reg;
    assign saturated     = sat_reg;
    assign cos_near_zero = near_reg;
    assign cfg_ready     = 1'b1;

    a_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
        alu_done |-> (state_reg == tsct_pkg::ST_X2W || state_reg == tsct_pkg::ST_MULW
                   || state_reg == tsct_pkg::ST_DIVW || state_reg == tsct_pkg::ST_TDIVW))
        else $error("shared unit finished while the sequencer was not waiting");

    a_near_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && cos_near_zero) |-> (value == '0 && !saturated))
        else $error("near-zero cosine result is not a plain zero");

    a_near_only_tan: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && sel_reg != tsct_pkg::REQ_TAN) |-> !cos_near_zero)
        else $error("near-zero flag raised for a non-tangent request");

    a_term_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tsct_pkg::ST_CHECK) |-> (n_reg <= NW'(MAX_TERMS)))
        else $error("term counter ran past its limit");

endmodule
